// ===== hw/rtl/round_robin_bounded_queue_server_top_macros.svh =====
// assertion macros for the round-robin queue server checker
// no dependencies; included by the checker file only
`ifndef ROUND_ROBIN_BOUNDED_QUEUE_SERVER_TOP_MACROS_SVH
`define ROUND_ROBIN_BOUNDED_QUEUE_SERVER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define RRBQS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RRBQS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rrbqs_pkg.sv =====
// shared types, widths and codes of the round-robin queue server
// no dependencies
package rrbqs_pkg;

  localparam int unsigned QUEUE_COUNT_DEF = 3;
  localparam int unsigned QUEUE_MAX       = 3;
  localparam int unsigned FIFO_DEPTH      = 4;

  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned QIDX_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LIMIT_W   = 8;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned DROP_W    = 32;
  localparam int unsigned SYS_W     = 10;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned AREA_W    = 64;
  localparam int unsigned PROD_W    = TIME_W + SYS_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd20;

  // action codes on the input channel
  localparam logic [ACTION_W-1:0] ACT_ARRIVE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_COMPLETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REPORT   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ONE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TWO  = 2'd2;

  typedef enum logic [1:0] {
    OP_ARRIVE,
    OP_COMPLETE,
    OP_REPORT,
    OP_IGNORE
  } op_e;

  typedef enum logic [2:0] {
    ST_QUEUED  = 3'd0,
    ST_STARTED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_NEXT    = 3'd3,
    ST_IDLE    = 3'd4,
    ST_REPORT  = 3'd5,
    ST_IGNORED = 3'd6
  } status_e;

  // classified event as held in the front queue
  typedef struct packed {
    op_e                op;
    logic [QIDX_W-1:0]  queue;
    logic [TIME_W-1:0]  stamp;
  } item_t;

  // result snapshot, all fields but the area sum
  typedef struct packed {
    status_e                           status;
    logic [QIDX_W-1:0]                 served;
    logic [QUEUE_MAX-1:0][COUNT_W-1:0] length;
    logic [SYS_W-1:0]                  in_system;
    logic                              busy;
    logic [QUEUE_MAX-1:0][DROP_W-1:0]  drops;
    logic [DROP_W-1:0]                 accepted;
  } snap_t;

endpackage

// ===== hw/rtl/rrbqs_front.sv =====
// front end: decodes input transactions and buffers them in a short queue
// depends on rrbqs_pkg
module rrbqs_front #(
  parameter int unsigned QueueCount = rrbqs_pkg::QUEUE_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rrbqs_pkg::ACTION_W-1:0]    action_i,
  input  logic [rrbqs_pkg::QIDX_W-1:0]      queue_index_i,
  input  logic [rrbqs_pkg::TIME_W-1:0]      event_time_i,
  input  logic                              pop_i,
  output logic                              item_valid_o,
  output rrbqs_pkg::item_t                  item_o
);

  localparam int unsigned PtrW = $clog2(rrbqs_pkg::FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(rrbqs_pkg::FIFO_DEPTH + 1);

  rrbqs_pkg::item_t mem_q [rrbqs_pkg::FIFO_DEPTH];
  rrbqs_pkg::item_t item_in;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push;

  // classify
  always_comb begin
    item_in.queue = queue_index_i;
    item_in.stamp = event_time_i;
    case (action_i)
      rrbqs_pkg::ACT_ARRIVE: begin
        item_in.op = (queue_index_i < rrbqs_pkg::QIDX_W'(QueueCount)) ?
                     rrbqs_pkg::OP_ARRIVE : rrbqs_pkg::OP_IGNORE;
      end
      rrbqs_pkg::ACT_COMPLETE: item_in.op = rrbqs_pkg::OP_COMPLETE;
      rrbqs_pkg::ACT_REPORT:   item_in.op = rrbqs_pkg::OP_REPORT;
      default:                 item_in.op = rrbqs_pkg::OP_IGNORE;
    endcase
  end

  assign in_stall_o   = (cnt_q == CntW'(rrbqs_pkg::FIFO_DEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ===== hw/rtl/rrbqs_sched.sv =====
// back end, first stage: queue counters, round-robin pick and area product
// depends on rrbqs_pkg
module rrbqs_sched #(
  parameter int unsigned QueueCount = rrbqs_pkg::QUEUE_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rrbqs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rrbqs_pkg::LIMIT_W-1:0]     cfg_data_i,
  input  logic                              item_valid_i,
  input  rrbqs_pkg::item_t                  item_i,
  output logic                              item_pop_o,
  input  logic                              acc_ready_i,
  output logic                              snap_valid_o,
  output rrbqs_pkg::snap_t                  snap_o,
  output logic [rrbqs_pkg::PROD_W-1:0]      prod_o
);

  localparam int unsigned QIdxW = (QueueCount > 1) ? $clog2(QueueCount) : 1;

  function automatic logic [rrbqs_pkg::DROP_W-1:0] sat_inc(
    input logic [rrbqs_pkg::DROP_W-1:0] v
  );
    return (&v) ? v : v + 1'b1;
  endfunction

  // queue visited step+1 places after the last one served
  function automatic logic [QIdxW-1:0] rr_next(input logic [QIdxW-1:0] last,
                                               input int unsigned step);
    logic [QIdxW:0] sum;
    sum = {1'b0, last} + (QIdxW+1)'(step + 1);
    if (sum >= (QIdxW+1)'(QueueCount)) begin
      sum = sum - (QIdxW+1)'(QueueCount);
    end
    return sum[QIdxW-1:0];
  endfunction

  logic [rrbqs_pkg::QUEUE_MAX-1:0][rrbqs_pkg::LIMIT_W-1:0] limit_q;

  logic [rrbqs_pkg::COUNT_W-1:0] wait_q [QueueCount];
  logic [rrbqs_pkg::COUNT_W-1:0] wait_d [QueueCount];
  logic [rrbqs_pkg::DROP_W-1:0]  drop_q [QueueCount];
  logic [rrbqs_pkg::DROP_W-1:0]  drop_d [QueueCount];
  logic                          busy_q, busy_d;
  logic [QIdxW-1:0]              last_q, last_d;
  logic [rrbqs_pkg::SYS_W-1:0]   sys_q, sys_d;
  logic [rrbqs_pkg::DROP_W-1:0]  acc_q, acc_d;
  logic [rrbqs_pkg::TIME_W-1:0]  prev_q, delta;

  logic                          snap_vld_q, snap_vld_d;
  rrbqs_pkg::snap_t              snap_q, snap_d;
  logic [rrbqs_pkg::PROD_W-1:0]  prod_q, prod_d;

  logic [QIdxW-1:0]              qi, pick;
  logic                          pick_found, full, fire;
  rrbqs_pkg::status_e            status;
  logic [rrbqs_pkg::QIDX_W-1:0]  served;

  assign fire       = item_valid_i && (!snap_vld_q || acc_ready_i);
  assign item_pop_o = fire;
  assign qi         = item_i.queue[QIdxW-1:0];
  assign full       = (wait_q[qi] >= limit_q[item_i.queue]);

  // first non-empty queue after the last one served
  always_comb begin
    pick_found = 1'b0;
    pick       = '0;
    for (int k = 0; k < QueueCount; k++) begin
      if (!pick_found && (wait_q[rr_next(last_q, k)] != '0)) begin
        pick_found = 1'b1;
        pick       = rr_next(last_q, k);
      end
    end
  end

  always_comb begin
    wait_d = wait_q;
    drop_d = drop_q;
    busy_d = busy_q;
    last_d = last_q;
    sys_d  = sys_q;
    acc_d  = acc_q;
    status = rrbqs_pkg::ST_IGNORED;
    served = '0;
    case (item_i.op)
      rrbqs_pkg::OP_ARRIVE: begin
        if (!full) begin
          acc_d = sat_inc(acc_q);
          sys_d = sys_q + 1'b1;
          if (!busy_q) begin
            busy_d = 1'b1;
            status = rrbqs_pkg::ST_STARTED;
            served = item_i.queue;
          end else begin
            wait_d[qi] = wait_q[qi] + 1'b1;
            status     = rrbqs_pkg::ST_QUEUED;
          end
        end else begin
          drop_d[qi] = sat_inc(drop_q[qi]);
          status     = rrbqs_pkg::ST_DROPPED;
        end
      end
      rrbqs_pkg::OP_COMPLETE: begin
        if (busy_q) begin
          sys_d = sys_q - 1'b1;
          if (pick_found) begin
            last_d       = pick;
            wait_d[pick] = wait_q[pick] - 1'b1;
            status       = rrbqs_pkg::ST_NEXT;
            served       = rrbqs_pkg::QIDX_W'(pick);
          end else begin
            busy_d = 1'b0;
            status = rrbqs_pkg::ST_IDLE;
          end
        end
      end
      rrbqs_pkg::OP_REPORT: status = rrbqs_pkg::ST_REPORT;
      default:              status = rrbqs_pkg::ST_IGNORED;
    endcase
  end

  // snapshot after the event; queues beyond the count read zero
  always_comb begin
    snap_d           = '0;
    snap_d.status    = status;
    snap_d.served    = served;
    snap_d.in_system = sys_d;
    snap_d.busy      = busy_d;
    snap_d.accepted  = acc_d;
    for (int i = 0; i < QueueCount; i++) begin
      snap_d.length[i] = wait_d[i];
      snap_d.drops[i]  = drop_d[i];
    end
  end

  // backwards time counts as no elapsed time
  assign delta  = (item_i.stamp >= prev_q) ? item_i.stamp - prev_q : '0;
  assign prod_d = rrbqs_pkg::PROD_W'(delta) * rrbqs_pkg::PROD_W'(sys_q);

  assign snap_vld_d = fire ? 1'b1 : (acc_ready_i ? 1'b0 : snap_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= {rrbqs_pkg::QUEUE_MAX{rrbqs_pkg::LIMIT_RESET}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rrbqs_pkg::CFG_LIMIT_ZERO: limit_q[rrbqs_pkg::CFG_LIMIT_ZERO] <= cfg_data_i;
        rrbqs_pkg::CFG_LIMIT_ONE:  limit_q[rrbqs_pkg::CFG_LIMIT_ONE]  <= cfg_data_i;
        rrbqs_pkg::CFG_LIMIT_TWO:  limit_q[rrbqs_pkg::CFG_LIMIT_TWO]  <= cfg_data_i;
        default:                   limit_q <= limit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q     <= '{default: '0};
      drop_q     <= '{default: '0};
      busy_q     <= 1'b0;
      last_q     <= QIdxW'(QueueCount - 1);
      sys_q      <= '0;
      acc_q      <= '0;
      prev_q     <= '0;
      snap_vld_q <= 1'b0;
    end else begin
      snap_vld_q <= snap_vld_d;
      if (fire) begin
        wait_q <= wait_d;
        drop_q <= drop_d;
        busy_q <= busy_d;
        last_q <= last_d;
        sys_q  <= sys_d;
        acc_q  <= acc_d;
        prev_q <= item_i.stamp;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      snap_q <= snap_d;
      prod_q <= prod_d;
    end
  end

  assign snap_valid_o = snap_vld_q;
  assign snap_o       = snap_q;
  assign prod_o       = prod_q;

endmodule

// ===== hw/rtl/rrbqs_accum.sv =====
// back end, second stage: saturating area sum and the output register
// depends on rrbqs_pkg
module rrbqs_accum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              snap_valid_i,
  input  rrbqs_pkg::snap_t                  snap_i,
  input  logic [rrbqs_pkg::PROD_W-1:0]      prod_i,
  output logic                              ready_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rrbqs_pkg::snap_t                  out_snap_o,
  output logic [rrbqs_pkg::AREA_W-1:0]      area_o
);

  logic                           out_vld_q, out_vld_d;
  rrbqs_pkg::snap_t               out_snap_q;
  logic [rrbqs_pkg::AREA_W-1:0]   area_q, area_d;
  logic [rrbqs_pkg::AREA_W:0]     sum;
  logic                           load;

  assign ready_o = !out_vld_q || !out_stall_i;
  assign load    = snap_valid_i && ready_o;

  assign sum    = {1'b0, area_q} + (rrbqs_pkg::AREA_W+1)'(prod_i);
  assign area_d = sum[rrbqs_pkg::AREA_W] ? '1 : sum[rrbqs_pkg::AREA_W-1:0];

  assign out_vld_d = load ? 1'b1 : (out_stall_i ? out_vld_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      area_q    <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      if (load) begin
        area_q <= area_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_snap_q <= snap_i;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_snap_o  = out_snap_q;
  assign area_o      = area_q;

endmodule

// ===== hw/rtl/round_robin_bounded_queue_server_top.sv =====
// top level of the round-robin bounded queue server
// depends on rrbqs_pkg, rrbqs_front, rrbqs_sched and rrbqs_accum
//
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   action, queue_index, event_time
// out       output     out_valid_o / out_stall_i status .. accepted_count
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// one event per clock sustained while the output is not stalled; scheduler state updates once per event
// a result passes the front queue, the scheduler snapshot register and the output register
// reset: limits 20, all counts and the area sum zero, queue zero checked first
// the four-entry front queue keeps taking transactions while the output is stalled
// in_stall_o rises only once that queue is full
module round_robin_bounded_queue_server_top #(
  parameter int unsigned QueueCount = rrbqs_pkg::QUEUE_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input transactions
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rrbqs_pkg::ACTION_W-1:0]    action_i,
  input  logic [rrbqs_pkg::QIDX_W-1:0]      queue_index_i,
  input  logic [rrbqs_pkg::TIME_W-1:0]      event_time_i,
  // result transactions
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        status_o,
  output logic [rrbqs_pkg::QIDX_W-1:0]      served_queue_o,
  output logic [rrbqs_pkg::COUNT_W-1:0]     length_zero_o,
  output logic [rrbqs_pkg::COUNT_W-1:0]     length_one_o,
  output logic [rrbqs_pkg::COUNT_W-1:0]     length_two_o,
  output logic [rrbqs_pkg::SYS_W-1:0]       in_system_o,
  output logic                              server_busy_o,
  output logic [rrbqs_pkg::DROP_W-1:0]      drops_zero_o,
  output logic [rrbqs_pkg::DROP_W-1:0]      drops_one_o,
  output logic [rrbqs_pkg::DROP_W-1:0]      drops_two_o,
  output logic [rrbqs_pkg::AREA_W-1:0]      occupancy_area_o,
  output logic [rrbqs_pkg::DROP_W-1:0]      accepted_count_o,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [rrbqs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rrbqs_pkg::LIMIT_W-1:0]     cfg_data_i
);

  // front to scheduler
  logic             item_valid, item_pop;
  rrbqs_pkg::item_t item;

  // scheduler to accumulator
  logic                          snap_valid, acc_ready;
  rrbqs_pkg::snap_t              snap;
  logic [rrbqs_pkg::PROD_W-1:0]  prod;

  // output register contents
  rrbqs_pkg::snap_t              out_snap;

  // decode and buffer
  rrbqs_front #(
    .QueueCount (QueueCount)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .queue_index_i (queue_index_i),
    .event_time_i  (event_time_i),
    .pop_i         (item_pop),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  // queue state, round-robin pick, elapsed time times occupancy
  rrbqs_sched #(
    .QueueCount (QueueCount)
  ) u_sched (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .acc_ready_i  (acc_ready),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .prod_o       (prod)
  );

  // saturating area sum and result register
  rrbqs_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .prod_i       (prod),
    .ready_o      (acc_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_snap_o   (out_snap),
    .area_o       (occupancy_area_o)
  );

  // unpack the result fields
  assign status_o         = out_snap.status;
  assign served_queue_o   = out_snap.served;
  assign length_zero_o    = out_snap.length[0];
  assign length_one_o     = out_snap.length[1];
  assign length_two_o     = out_snap.length[2];
  assign in_system_o      = out_snap.in_system;
  assign server_busy_o    = out_snap.busy;
  assign drops_zero_o     = out_snap.drops[0];
  assign drops_one_o      = out_snap.drops[1];
  assign drops_two_o      = out_snap.drops[2];
  assign accepted_count_o = out_snap.accepted;

endmodule

// ===== hw/rtl/rrbqs_checker.sv =====
// port-level checks of the round-robin queue server, bound to the top level
// depends on rrbqs_pkg and round_robin_bounded_queue_server_top_macros.svh
`include "round_robin_bounded_queue_server_top_macros.svh"

module rrbqs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [2:0]                        status_o,
  input logic [rrbqs_pkg::QIDX_W-1:0]      served_queue_o,
  input logic [rrbqs_pkg::COUNT_W-1:0]     length_zero_o,
  input logic [rrbqs_pkg::COUNT_W-1:0]     length_one_o,
  input logic [rrbqs_pkg::COUNT_W-1:0]     length_two_o,
  input logic [rrbqs_pkg::SYS_W-1:0]       in_system_o,
  input logic                              server_busy_o,
  input logic [rrbqs_pkg::AREA_W-1:0]      occupancy_area_o,
  input logic [rrbqs_pkg::DROP_W-1:0]      accepted_count_o
);

  logic [rrbqs_pkg::SYS_W-1:0] held_sum;

  // waiting entries plus the one in service
  assign held_sum = rrbqs_pkg::SYS_W'(length_zero_o) + rrbqs_pkg::SYS_W'(length_one_o) +
                    rrbqs_pkg::SYS_W'(length_two_o) + rrbqs_pkg::SYS_W'(server_busy_o);

  `RRBQS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(occupancy_area_o) && $stable(accepted_count_o), "stalled result changed")

  `RRBQS_ASSERT_IMP(a_system_sum, clk_i, rst_ni, out_valid_o, in_system_o == held_sum, "in_system differs from queue lengths plus server")

  `RRBQS_ASSERT_IMP(a_service_busy, clk_i, rst_ni, out_valid_o && (status_o == rrbqs_pkg::ST_STARTED || status_o == rrbqs_pkg::ST_NEXT), server_busy_o && (in_system_o != '0), "service start with idle server")

  `RRBQS_ASSERT_IMP(a_idle_empty, clk_i, rst_ni, out_valid_o && (status_o == rrbqs_pkg::ST_IDLE), !server_busy_o && (in_system_o == '0), "server went idle with entries left")

  `RRBQS_ASSERT_IMP(a_served_zero, clk_i, rst_ni, out_valid_o && (served_queue_o != '0), status_o == rrbqs_pkg::ST_STARTED || status_o == rrbqs_pkg::ST_NEXT, "served queue set without a service start")

endmodule

bind round_robin_bounded_queue_server_top rrbqs_checker u_rrbqs_checker (.*);
